>>> sv/accumulator_cpu_execute_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef ACCUMULATOR_CPU_EXECUTE_UNIT_DEFINES_SVH
`define ACCUMULATOR_CPU_EXECUTE_UNIT_DEFINES_SVH

// Checked only outside reset.
`define ACCEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ACCEU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/acceu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acceu_pkg;

  localparam int OPC_W       = 5;
  localparam int OPD_W       = 11;
  localparam int DATA_W      = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam int DATA_DEPTH_DEF = 2048;
  localparam int IO_DEPTH_DEF   = 32;

  // instruction codes
  localparam logic [OPC_W-1:0] OP_WM   = 5'h01;
  localparam logic [OPC_W-1:0] OP_RM   = 5'h02;
  localparam logic [OPC_W-1:0] OP_BR   = 5'h03;
  localparam logic [OPC_W-1:0] OP_RIO  = 5'h04;
  localparam logic [OPC_W-1:0] OP_WIO  = 5'h05;
  localparam logic [OPC_W-1:0] OP_WB   = 5'h06;
  localparam logic [OPC_W-1:0] OP_WIB  = 5'h07;
  localparam logic [OPC_W-1:0] OP_WACC = 5'h09;
  localparam logic [OPC_W-1:0] OP_RACC = 5'h0B;
  localparam logic [OPC_W-1:0] OP_SWAP = 5'h0E;
  localparam logic [OPC_W-1:0] OP_BRLT = 5'h11;
  localparam logic [OPC_W-1:0] OP_BRGT = 5'h12;
  localparam logic [OPC_W-1:0] OP_BRNE = 5'h13;
  localparam logic [OPC_W-1:0] OP_BRE  = 5'h14;
  localparam logic [OPC_W-1:0] OP_SHR  = 5'h15;
  localparam logic [OPC_W-1:0] OP_SHL  = 5'h16;
  localparam logic [OPC_W-1:0] OP_XOR  = 5'h17;
  localparam logic [OPC_W-1:0] OP_NOT  = 5'h18;
  localparam logic [OPC_W-1:0] OP_OR   = 5'h19;
  localparam logic [OPC_W-1:0] OP_AND  = 5'h1A;
  localparam logic [OPC_W-1:0] OP_MUL  = 5'h1B;
  localparam logic [OPC_W-1:0] OP_SUB  = 5'h1D;
  localparam logic [OPC_W-1:0] OP_ADD  = 5'h1E;
  localparam logic [OPC_W-1:0] OP_EOP  = 5'h1F;

  typedef enum logic [3:0] {
    ALU_ADD = 4'd0,
    ALU_SUB = 4'd1,
    ALU_AND = 4'd2,
    ALU_OR  = 4'd3,
    ALU_XOR = 4'd4,
    ALU_NOT = 4'd5,
    ALU_SHL = 4'd6,
    ALU_SHR = 4'd7,
    ALU_MUL = 4'd8
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> sv/acceu_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared 8-bit ALU. One adder serves add, subtract and every step of the
// radix-2 Booth multiply (eight steps, one a cycle).
module acceu_alu (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire acceu_pkg::alu_req_t req,
  output acceu_pkg::alu_rsp_t     rsp
);
  import acceu_pkg::*;

  localparam int MUL_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] pa;
  logic [DATA_W-1:0] pq;
  logic              pqm1;
  logic [DATA_W-1:0] pm;
  logic [DATA_W-1:0] res;

  logic [DATA_W-1:0] add_x;
  logic [DATA_W-1:0] add_y;
  logic              add_sub;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] a_next;
  logic [DATA_W-1:0] single;
  logic              big_shift;

  always_comb begin
    if (busy) begin
      add_x   = pa;
      add_y   = pm;
      add_sub = pq[0] & ~pqm1;
    end else begin
      add_x   = req.a;
      add_y   = req.b;
      add_sub = (req.op == ALU_SUB);
    end
    sum = add_x + (add_sub ? ~add_y : add_y) + DATA_W'(add_sub);
  end

  // Booth: add or subtract only when q0 and q-1 differ
  assign a_next    = (pq[0] ^ pqm1) ? sum : pa;
  assign big_shift = (req.b[DATA_W-1:3] != '0);

  always_comb begin
    case (req.op)
      ALU_ADD: single = sum;
      ALU_SUB: single = sum;
      ALU_AND: single = req.a & req.b;
      ALU_OR:  single = req.a | req.b;
      ALU_XOR: single = req.a ^ req.b;
      ALU_NOT: single = ~req.a;
      ALU_SHL: single = big_shift ? '0 : (req.a << req.b[2:0]);
      ALU_SHR: single = big_shift ? '0 : (req.a >> req.b[2:0]);
      default: single = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      done <= (cnt == CNT_W'(MUL_STEPS - 1));
      if (cnt == CNT_W'(MUL_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= req.start && (req.op != ALU_MUL);
      if (req.start && (req.op == ALU_MUL)) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      pa   <= {a_next[DATA_W-1], a_next[DATA_W-1:1]};
      pq   <= {a_next[0], pq[DATA_W-1:1]};
      pqm1 <= pq[0];
      if (cnt == CNT_W'(MUL_STEPS - 1)) begin
        res <= {a_next[0], pq[DATA_W-1:1]};
      end
    end else if (req.start) begin
      if (req.op == ALU_MUL) begin
        pa   <= '0;
        pq   <= req.b;
        pqm1 <= 1'b0;
        pm   <= req.a;
      end else begin
        res <= single;
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = res;

endmodule

`default_nettype wire

>>> sv/accumulator_cpu_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tuser: opcode[4:0]; tdata: operand[10:0]
// m_axis    out        tdata: next_pc, acc, mbr, iobr, flags, halted, io_fault
//
// Path per instruction: register, jump and store ops, out-of-range reads
// and anything once halted go from EXEC to FIN; in-range data/I/O reads
// pass a registered memory read in MEMRD; ALU ops and compares wait in
// ALU, multiply there for eight Booth steps through the shared adder.
// After reset a clearing pass zeroes every address of both stores;
// s_axis_tready stays low until it ends.
// The input is taken again while a result beat still waits on m_axis.
module accumulator_cpu_execute_unit #(
  parameter int DATA_DEPTH = acceu_pkg::DATA_DEPTH_DEF,
  parameter int IO_DEPTH   = acceu_pkg::IO_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [10:0] operand
  input  wire logic [acceu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [4:0] opcode
  input  wire logic [acceu_pkg::OPC_W-1:0]         s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [10:0] next_pc, [18:11] acc_value, [26:19] mbr_value, [34:27] iobr_value,
  // [35] zero_flag, [36] sign_flag, [37] overflow_flag, [38] carry_flag,
  // [39] halted, [40] io_fault
  output logic [acceu_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
  import acceu_pkg::*;

  localparam int DATA_AW   = $clog2(DATA_DEPTH);
  localparam int IO_AW     = $clog2(IO_DEPTH);
  localparam int CLR_DEPTH = (DATA_DEPTH > IO_DEPTH) ? DATA_DEPTH : IO_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);
  localparam logic [CLR_AW-1:0] CLR_LAST    = CLR_AW'(CLR_DEPTH - 1);
  localparam logic [CLR_AW:0]   CLR_DATA_LIM = (CLR_AW + 1)'(DATA_DEPTH);
  localparam logic [CLR_AW:0]   CLR_IO_LIM   = (CLR_AW + 1)'(IO_DEPTH);
  localparam logic [OPD_W:0]    DATA_LIM     = (OPD_W + 1)'(DATA_DEPTH);
  localparam logic [OPD_W:0]    IO_LIM       = (OPD_W + 1)'(IO_DEPTH);
  localparam logic [OPD_W-1:0]  PC_STEP      = OPD_W'(2);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_MEMRD = 6'b001000,
    ST_ALU   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state;

  logic [CLR_AW-1:0] clr_cnt;
  logic [OPC_W-1:0]  op_r;
  logic [OPD_W-1:0]  opd_r;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] mbr;
  logic [DATA_W-1:0] iobr;
  logic [OPD_W-1:0]  pc;
  logic              flag_z;
  logic              flag_s;
  logic              halt;
  logic              fault;
  logic              out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  logic [DATA_W-1:0] data_mem [DATA_DEPTH];
  logic [DATA_W-1:0] io_mem [IO_DEPTH];
  logic [DATA_W-1:0] dm_rdata;
  logic [DATA_W-1:0] iom_rdata;

  logic               clearing;
  logic               exec;
  logic               data_in_range;
  logic               io_in_range;
  logic               dm_we;
  logic               dm_re;
  logic [DATA_AW-1:0] dm_waddr;
  logic [DATA_W-1:0]  dm_wdata;
  logic               iom_we;
  logic               iom_re;
  logic [IO_AW-1:0]   iom_waddr;
  logic [DATA_W-1:0]  iom_wdata;

  logic     alu_use;
  alu_op_t  alu_op;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     take;

  assign clearing      = (state == ST_CLEAR);
  assign exec          = (state == ST_EXEC) && !halt;
  assign data_in_range = ({1'b0, opd_r} < DATA_LIM);
  assign io_in_range   = ({1'b0, opd_r} < IO_LIM);

  always_comb begin
    alu_use = 1'b1;
    case (op_r)
      OP_ADD:  alu_op = ALU_ADD;
      OP_SUB:  alu_op = ALU_SUB;
      OP_AND:  alu_op = ALU_AND;
      OP_OR:   alu_op = ALU_OR;
      OP_XOR:  alu_op = ALU_XOR;
      OP_NOT:  alu_op = ALU_NOT;
      OP_SHL:  alu_op = ALU_SHL;
      OP_SHR:  alu_op = ALU_SHR;
      OP_MUL:  alu_op = ALU_MUL;
      OP_BRLT: alu_op = ALU_SUB;
      OP_BRGT: alu_op = ALU_SUB;
      OP_BRNE: alu_op = ALU_SUB;
      OP_BRE:  alu_op = ALU_SUB;
      default: begin
        alu_op  = ALU_ADD;
        alu_use = 1'b0;
      end
    endcase
  end

  assign alu_req.start = exec && alu_use;
  assign alu_req.op    = alu_op;
  assign alu_req.a     = acc;
  assign alu_req.b     = mbr;

  acceu_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // branch decision on the fresh difference
  always_comb begin
    case (op_r)
      OP_BRE:  take = (alu_rsp.result == '0);
      OP_BRNE: take = (alu_rsp.result != '0);
      OP_BRGT: take = !alu_rsp.result[DATA_W-1];
      OP_BRLT: take = alu_rsp.result[DATA_W-1];
      default: take = 1'b0;
    endcase
  end

  // store ports: the clearing pass owns the write side until it ends
  always_comb begin
    if (clearing) begin
      dm_we     = ({1'b0, clr_cnt} < CLR_DATA_LIM);
      dm_waddr  = clr_cnt[DATA_AW-1:0];
      dm_wdata  = '0;
      iom_we    = ({1'b0, clr_cnt} < CLR_IO_LIM);
      iom_waddr = clr_cnt[IO_AW-1:0];
      iom_wdata = '0;
    end else begin
      dm_we     = exec && (op_r == OP_WM) && data_in_range;
      dm_waddr  = opd_r[DATA_AW-1:0];
      dm_wdata  = mbr;
      iom_we    = exec && (op_r == OP_WIO) && io_in_range;
      iom_waddr = opd_r[IO_AW-1:0];
      iom_wdata = iobr;
    end
  end

  assign dm_re  = exec && (op_r == OP_RM) && data_in_range;
  assign iom_re = exec && (op_r == OP_RIO) && io_in_range;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_rdata <= data_mem[opd_r[DATA_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (iom_we) begin
      io_mem[iom_waddr] <= iom_wdata;
    end
    if (iom_re) begin
      iom_rdata <= io_mem[opd_r[IO_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      op_r  <= s_axis_tuser;
      opd_r <= s_axis_tdata[OPD_W-1:0];
    end
    if (state == ST_FIN && (!out_valid || m_axis_tready)) begin
      // overflow mirrors sign; carry never sets on an 8-bit accumulator
      out_data <= {7'b0, fault, halt, 1'b0, flag_s, flag_s, flag_z, iobr, mbr, acc, pc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      acc       <= '0;
      mbr       <= '0;
      iobr      <= '0;
      pc        <= '0;
      flag_z    <= 1'b0;
      flag_s    <= 1'b0;
      halt      <= 1'b0;
      fault     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // in ST_FIN the beat register is reloaded instead
      if (m_axis_tready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          fault <= !halt && ((op_r == OP_RIO) || (op_r == OP_WIO)) && !io_in_range;
          if (halt) begin
            state <= ST_FIN;
          end else if (alu_use) begin
            state <= ST_ALU;
          end else if (((op_r == OP_RM) && data_in_range) ||
                       ((op_r == OP_RIO) && io_in_range)) begin
            state <= ST_MEMRD;
          end else begin
            state <= ST_FIN;
          end
          if (!halt) begin
            pc <= (op_r == OP_BR) ? opd_r : pc + PC_STEP;
            case (op_r)
              OP_RM: begin
                if (!data_in_range) begin
                  mbr <= '0;
                end
              end
              OP_WB:  mbr <= opd_r[DATA_W-1:0];
              OP_WIB: iobr <= opd_r[DATA_W-1:0];
              OP_WACC: begin
                acc    <= mbr;
                flag_z <= (mbr == '0);
                flag_s <= mbr[DATA_W-1];
              end
              OP_RACC: begin
                mbr    <= acc;
                flag_z <= (acc == '0);
                flag_s <= acc[DATA_W-1];
              end
              OP_SWAP: begin
                mbr  <= iobr;
                iobr <= mbr;
              end
              OP_EOP: halt <= 1'b1;
              default: ;
            endcase
          end
        end
        ST_MEMRD: begin
          if (op_r == OP_RM) begin
            mbr <= dm_rdata;
          end else begin
            iobr <= iom_rdata;
          end
          state <= ST_FIN;
        end
        ST_ALU: begin
          if (alu_rsp.done) begin
            acc    <= alu_rsp.result;
            flag_z <= (alu_rsp.result == '0);
            flag_s <= alu_rsp.result[DATA_W-1];
            if (take) begin
              pc <= opd_r;
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

>>> sv/acceu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "accumulator_cpu_execute_unit_defines.svh"

module acceu_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [acceu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic [acceu_pkg::OPC_W-1:0]       s_axis_tuser,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [acceu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import acceu_pkg::*;

  logic [DATA_W-1:0] acc_seen;
  logic              z_seen;
  logic              s_seen;
  logic              o_seen;
  logic              c_seen;

  assign acc_seen = m_axis_tdata[18:11];
  assign z_seen   = m_axis_tdata[35];
  assign s_seen   = m_axis_tdata[36];
  assign o_seen   = m_axis_tdata[37];
  assign c_seen   = m_axis_tdata[38];

  // clearing pass keeps the input closed and no beat is left over from before
  `ACCEU_ASSERT_ALWAYS(a_reset_quiet, rst |=> (!s_axis_tready && !m_axis_tvalid), "busy after reset")
  // flags only move with the accumulator, so a set flag must match it
  `ACCEU_ASSERT(a_zero_flag, (m_axis_tvalid && z_seen) |-> (acc_seen == '0), "zero flag stale")
  `ACCEU_ASSERT(a_sign_flag, (m_axis_tvalid && s_seen) |-> acc_seen[DATA_W-1], "sign flag stale")
  `ACCEU_ASSERT(a_ovf_carry, m_axis_tvalid |-> ((o_seen == s_seen) && !c_seen), "ovf/carry wrong")

endmodule

bind accumulator_cpu_execute_unit acceu_checker u_acceu_checker (.*);

`default_nettype wire
